@@ src/pxp_pkg.sv @@
package pxp_pkg;

  localparam int unsigned FRAME_W   = 19;
  localparam int unsigned PATTERN_W = 8;
  localparam int unsigned COUNT_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_ZERO = 8'h00;

  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [PATTERN_W-1:0] pattern_value;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] run_count;
    logic               frame_last;
  } out_word_t;

  // per-pixel update command handed from position tracking to the update stage
  typedef struct packed {
    logic fill;
    logic tick;
    logic pat_nz;
    logic last;
  } issue_t;

endpackage

@@ src/pxp_ram.sv @@
module pxp_ram #(
  parameter int unsigned DEPTH = 262144,
  parameter int unsigned AW    = 18
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [pxp_pkg::COUNT_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [pxp_pkg::COUNT_W-1:0] wr_data_i
);
  import pxp_pkg::*;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read returns the old contents when the same entry is written in this cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/pxp_pos.sv @@
module pxp_pos #(
  parameter int unsigned MAX_PIXELS = 262144,
  parameter int unsigned AW         = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pxp_pkg::FRAME_W-1:0] cfg_data_i,
  input  logic                        accept_i,
  input  pxp_pkg::in_word_t           word_i,
  output logic                        issue_o,
  output pxp_pkg::issue_t             cmd_o,
  output logic [AW-1:0]               addr_o
);
  import pxp_pkg::*;

  localparam int unsigned SW = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;
  localparam logic [SW-1:0] SIZE_MAX = SW'(MAX_PIXELS);
  localparam logic [SW-1:0] SIZE_ONE = SW'(1);

  logic [FRAME_W-1:0] frame_pixels_q;
  logic [AW-1:0]      pos_q, pos_d;
  logic               filled_q, filled_d;
  logic               first_q, first_d;

  logic [SW-1:0] size_raw, size_eff, pos_inc;
  logic          ignore, fill, last;

  always_comb begin
    size_raw = SW'(frame_pixels_q);
    if (size_raw == '0) begin
      size_eff = SIZE_ONE;
    end else if (size_raw > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end else begin
      size_eff = size_raw;
    end
    pos_inc = SW'(pos_q) + SIZE_ONE;
    last    = (pos_inc >= size_eff);
    ignore  = !filled_q && !first_q && (word_i.op == OP_TICK);
    fill    = first_q || (!filled_q && (word_i.op == OP_ACCUM));

    pos_d    = pos_q;
    filled_d = filled_q;
    first_d  = first_q;
    if (accept_i && !ignore) begin
      pos_d = last ? '0 : pos_inc[AW-1:0];
      if (fill && last) begin
        first_d  = 1'b0;
        filled_d = 1'b1;
      end else if (fill) begin
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= FRAME_W'(262144);
      pos_q          <= '0;
      filled_q       <= 1'b0;
      first_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_pixels_q <= cfg_data_i;
      end
      pos_q    <= pos_d;
      filled_q <= filled_d;
      first_q  <= first_d;
    end
  end

  assign issue_o       = accept_i && !ignore;
  assign addr_o        = pos_q;
  assign cmd_o.fill    = fill;
  assign cmd_o.tick    = (word_i.op == OP_TICK);
  assign cmd_o.pat_nz  = (word_i.pattern_value != '0);
  assign cmd_o.last    = last;

endmodule

@@ src/pxp_upd.sv @@
module pxp_upd #(
  parameter int unsigned AW = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  pxp_pkg::issue_t             cmd_i,
  input  logic [AW-1:0]               addr_i,
  output logic                        take_o,
  input  logic [pxp_pkg::COUNT_W-1:0] rd_data_i,
  output logic                        wr_en_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [pxp_pkg::COUNT_W-1:0] wr_data_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pxp_pkg::out_word_t          out_word_o
);
  import pxp_pkg::*;

  logic               s1_valid_q;
  issue_t             s1_cmd_q;
  logic [AW-1:0]      s1_addr_q;
  logic               fwd_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic               out_valid_q;
  out_word_t          out_word_q;

  logic               s1_adv;
  logic [COUNT_W-1:0] cur, next;

  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign take_o = !s1_valid_q || s1_adv;

  // a write leaving this stage in the same cycle as the read is forwarded
  assign cur = fwd_q ? fwd_data_q : rd_data_i;

  always_comb begin
    if (s1_cmd_q.fill) begin
      next = COUNT_MAX;
    end else if (!s1_cmd_q.tick) begin
      if (!s1_cmd_q.pat_nz) begin
        next = COUNT_ZERO;
      end else if (cur == COUNT_MAX) begin
        next = COUNT_MAX;
      end else begin
        next = cur + COUNT_W'(1);
      end
    end else begin
      if (cur == COUNT_MAX) begin
        next = COUNT_MAX;
      end else if (s1_cmd_q.pat_nz) begin
        next = cur + COUNT_W'(1);
      end else begin
        next = COUNT_ZERO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        s1_valid_q <= load_i;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_cmd_q   <= cmd_i;
      s1_addr_q  <= addr_i;
      fwd_q      <= s1_adv && (s1_addr_q == addr_i);
      fwd_data_q <= next;
    end
    if (s1_adv) begin
      out_word_q.run_count  <= next;
      out_word_q.frame_last <= s1_cmd_q.last;
    end
  end

  assign wr_en_o     = s1_adv;
  assign wr_addr_o   = s1_addr_q;
  assign wr_data_o   = next;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ src/pixel_persistence_counter_unit.sv @@
// per-pixel persistence counter over a frame store
// input channel: in_valid_i / in_stall_o with one pattern word per pixel in
//   raster order; the unit tracks the pixel position itself
// output channel: out_valid_o / out_stall_i with the new count of each pixel
//   and a flag on the last pixel of the frame
// config channel: cfg_valid_i / cfg_ready_o writes frame_pixels; ready is
//   always high, write only while no word is in flight
// path: an accepted word is read into the update stage together with its count,
//   and its result goes into the output register when the update stage moves on
// throughput: one word per cycle while the receiver does not stall, set by the
//   single read-modify-write on the count memory (read at accept, update and write back when the update stage moves on)
// the first accumulate word starts a fill frame that writes 255 to every pixel of the frame;
//   a tick word before that is consumed without a result
// reset clears position, fill state and the frame size register (262144);
//   the count memory holds garbage until the fill frame writes it
// when the receiver stalls, the output register holds and one more word
//   waits in the update stage, after which in_stall_o rises
module pixel_persistence_counter_unit #(
  parameter int unsigned MAX_PIXELS = 262144
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pxp_pkg::FRAME_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pxp_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pxp_pkg::out_word_t          out_word_o
);
  import pxp_pkg::*;

  // address width of the count memory
  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  logic               take;
  logic               accept;
  logic               issue;
  issue_t             cmd;
  logic [AW-1:0]      addr;
  logic [COUNT_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // a word is taken whenever the update stage is empty or moving on
  assign accept      = in_valid_i && take;
  assign in_stall_o  = !take;
  assign cfg_ready_o = 1'b1;

  // position, frame size and fill tracking
  pxp_pos #(
    .MAX_PIXELS(MAX_PIXELS),
    .AW        (AW)
  ) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i),
    .cfg_data_i(cfg_wdata_i),
    .accept_i  (accept),
    .word_i    (in_word_i),
    .issue_o   (issue),
    .cmd_o     (cmd),
    .addr_o    (addr)
  );

  // count store, read when a word is issued, written when the update stage moves on
  pxp_ram #(
    .DEPTH(MAX_PIXELS),
    .AW   (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (issue),
    .rd_addr_i(addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // count update, forwarding and output register
  pxp_upd #(
    .AW(AW)
  ) u_upd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (issue),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .take_o     (take),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule

@@ tb/pixel_count_checker.sv @@
module pixel_count_checker #(
  parameter int unsigned MAX_PIXELS = 262144
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [pxp_pkg::FRAME_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  pxp_pkg::in_word_t           in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  pxp_pkg::out_word_t          out_word_i,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pxp_pkg::*;

  localparam int unsigned FRAME_RESET = 262144;

  // shadow of the frame store and position tracking
  logic [COUNT_W-1:0] count_mem [MAX_PIXELS];
  logic [FRAME_W-1:0] frame_size;
  int unsigned        pixel_pos;
  bit                 store_filled;
  bit                 filling;
  out_word_t          expected_counts [$];

  // one read-modify-write of a pixel counter, returns 0 for an ignored word
  function automatic bit apply_pattern_pixel(input in_word_t w, output out_word_t res);
    int unsigned        eff;
    int unsigned        pos;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] nxt;
    bit                 last;
    res = '0;
    eff = (frame_size == '0) ? 1 : ((frame_size > MAX_PIXELS) ? MAX_PIXELS : frame_size);
    pos = (pixel_pos >= MAX_PIXELS) ? 0 : pixel_pos;
    if (!store_filled && !filling) begin
      if (w.op == OP_TICK) return 1'b0;
      filling = 1'b1;
    end
    cur = count_mem[pos];
    if (filling) begin
      nxt = COUNT_MAX;
    end else if (w.op == OP_ACCUM) begin
      if (w.pattern_value == '0) nxt = COUNT_ZERO;
      else nxt = (cur == COUNT_MAX) ? COUNT_MAX : COUNT_W'(cur + 1'b1);
    end else begin
      if (cur == COUNT_MAX) nxt = COUNT_MAX;
      else if (w.pattern_value != '0) nxt = COUNT_W'(cur + 1'b1);
      else nxt = COUNT_ZERO;
    end
    count_mem[pos] = nxt;
    last = (pos + 1 >= eff);
    if (last) begin
      pixel_pos = 0;
      if (filling) begin
        filling      = 1'b0;
        store_filled = 1'b1;
      end
    end else begin
      pixel_pos = pos + 1;
    end
    res.run_count  = nxt;
    res.frame_last = last;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t res;
    out_word_t want;
    if (!rst_ni) begin
      frame_size   = FRAME_W'(FRAME_RESET);
      pixel_pos    = 0;
      store_filled = 1'b0;
      filling      = 1'b0;
      expected_counts.delete();
      pending_o    = 0;
      errors_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        frame_size = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (apply_pattern_pixel(in_word_i, res)) expected_counts.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected result word: run_count %0d frame_last %0b",
                 out_word_i.run_count, out_word_i.frame_last);
          errors_o++;
        end else begin
          want = expected_counts.pop_front();
          if (out_word_i.run_count !== want.run_count) begin
            $error("run_count mismatch: expected %0d, actual %0d",
                   want.run_count, out_word_i.run_count);
            errors_o++;
          end
          if (out_word_i.frame_last !== want.frame_last) begin
            $error("frame_last mismatch: expected %0b, actual %0b",
                   want.frame_last, out_word_i.frame_last);
            errors_o++;
          end
        end
      end
      pending_o = expected_counts.size();
    end
  end

endmodule

@@ tb/pixel_persistence_counter_unit_tb.sv @@
module pixel_persistence_counter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pxp_pkg::*;

  localparam int unsigned MAX_PIXELS   = 262144;
  // pixels written by the fill frame; frames never reach past this area
  localparam int unsigned FILL_LEN     = 25;
  localparam int unsigned RANDOM_WORDS = 1500;
  localparam int unsigned FRAME_ALL1   = (1 << FRAME_W) - 1;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [FRAME_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_word_t           in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_word_t          out_word_o;

  int unsigned pending_words;
  int unsigned error_count;

  // idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // stimulus-side view of the pixel position, keeps reads inside the filled area
  int unsigned cur_pos  = 0;
  int unsigned cur_size = MAX_PIXELS;

  pixel_persistence_counter_unit #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  pixel_count_checker #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .pending_o   (pending_words),
    .errors_o    (error_count)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver backpressure, rate set by the current phase
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // hard stop in case the unit hangs
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // present one pattern word, optionally after idle cycles, and wait for acceptance
  task automatic send_word(input op_e op, input logic [PATTERN_W-1:0] pat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{op: op, pattern_value: pat};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // position wraps once it reaches the current frame size
    cur_pos = (cur_pos + 1 >= cur_size) ? 0 : cur_pos + 1;
  endtask

  // drain the pipe, then write the frame size register
  task automatic set_frame_size(input logic [FRAME_W-1:0] size_w);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    // ignored tick words leave nothing to wait for, so allow the pipe latency too
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= size_w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    // zero acts as one pixel, oversize clips to the store
    if (size_w == '0) cur_size = 1;
    else if (size_w > MAX_PIXELS) cur_size = MAX_PIXELS;
    else cur_size = size_w;
  endtask

  initial begin
    int unsigned              sent;
    int unsigned              phase;
    int unsigned              n_words;
    int unsigned              zero_pct;
    int unsigned              tick_pct;
    int unsigned              guard;
    logic [FRAME_W-1:0]       size_w;
    logic [PATTERN_W-1:0]     pat;
    op_e                      op;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // light idling on both sides for the directed part
    send_idle_pct = 18;
    stall_pct     = 18;

    // tick words before any fill are dropped without a result
    send_word(OP_TICK, 8'hFF);
    send_word(OP_TICK, 8'h00);

    // fill frame at the reset frame size: every pixel returns 255, either op
    send_word(OP_ACCUM, 8'h00);
    for (int i = 1; i < FILL_LEN - 1; i++) begin
      send_word(op_e'($urandom_range(0, 1)), PATTERN_W'($urandom));
    end
    // shrink below the current position, the next pixel closes the fill frame
    set_frame_size(FRAME_W'(8));
    send_word(OP_TICK, 8'h5A);
    cur_pos = 0;

    // one-pixel frame: clear, tick count up, tick clear, accumulate count up twice, tick clear
    set_frame_size(FRAME_W'(1));
    send_word(OP_ACCUM, 8'h00);
    send_word(OP_TICK, 8'h01);
    send_word(OP_TICK, 8'h00);
    send_word(OP_ACCUM, 8'h80);
    send_word(OP_ACCUM, 8'hFF);
    send_word(OP_TICK, 8'h00);

    // random phases, each with its own frame size, mix and idle pattern
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase)
        0: size_w = FRAME_W'(1);
        1: size_w = '0;
        2: size_w = FRAME_W'(MAX_PIXELS);
        3: size_w = FRAME_W'(FRAME_ALL1);
        4: size_w = FRAME_W'(FILL_LEN);
        default: begin
          case ($urandom_range(0, 3))
            0: size_w = FRAME_W'($urandom_range(1, FILL_LEN));
            1: size_w = FRAME_W'($urandom_range(1, 4));
            2: size_w = FRAME_W'($urandom_range(FILL_LEN + 1, FRAME_ALL1));
            default: size_w = FRAME_W'($urandom_range(2, FILL_LEN));
          endcase
        end
      endcase
      set_frame_size(size_w);

      // first phase runs one pixel long enough to climb into saturation
      n_words = (phase == 0) ? 300 : $urandom_range(20, 150);
      // large frames stop before the position leaves the filled area
      if (cur_size > FILL_LEN && n_words > FILL_LEN - 1 - cur_pos) begin
        n_words = FILL_LEN - 1 - cur_pos;
      end

      case ($urandom_range(0, 2))
        0: zero_pct = 3;
        1: zero_pct = 30;
        default: zero_pct = 70;
      endcase
      if (phase == 0) zero_pct = 0;
      case ($urandom_range(0, 2))
        0: tick_pct = 10;
        1: tick_pct = 50;
        default: tick_pct = 90;
      endcase

      case (phase % 5)
        1: begin
          send_idle_pct = 54;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 54;
        end
        3: begin
          send_idle_pct = 18;
          stall_pct     = 18;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase

      for (int i = 0; i < n_words; i++) begin
        op = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_ACCUM;
        if ($urandom_range(0, 99) < zero_pct) pat = '0;
        else if ($urandom_range(0, 3) == 0) pat = '1;
        else pat = PATTERN_W'($urandom_range(1, 255));
        send_word(op, pat);
        sent++;
      end
      phase++;
    end

    // wind down: no more words, no more backpressure, let results drain
    in_valid_i <= 1'b0;
    stall_pct = 0;
    guard     = 0;
    while (pending_words != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    if (error_count == 0 && pending_words == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/pxp_pkg.sv
src/pxp_ram.sv
src/pxp_pos.sv
src/pxp_upd.sv
src/pixel_persistence_counter_unit.sv
tb/pixel_count_checker.sv
tb/pixel_persistence_counter_unit_tb.sv
